// ===== sv/rgb_led_effect_generator_macros.svh =====
// Assertion macros shared by the RGB LED effect generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RGB_LED_EFFECT_GENERATOR_MACROS_SVH
`define RGB_LED_EFFECT_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBLED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbled: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RGBLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbled: next-cycle check failed");

`endif

// ===== sv/rgbled_pkg.sv =====
// Shared types, codes and helper functions for the RGB LED effect generator.
// No dependencies; used by the interfaces and every module.
package rgbled_pkg;

    localparam int SET_W           = 8;
    localparam int MAX_W           = 16;
    localparam int DUTY_OUT_W      = 16;
    localparam int PROD_W          = SET_W + MAX_W;
    localparam int REM_W           = 10;
    localparam int BYTE_FULL_SCALE = 255;

    localparam logic [MAX_W-1:0] MAX_LEVEL_RESET = 16'd999;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_STATIC = 3'd1,
        MODE_BLINK  = 3'd2,
        MODE_BREATH = 3'd3,
        MODE_SMOOTH = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_COLOR     = 2'd1,
        REG_MAX_LEVEL = 2'd2
    } reg_idx_t;

    localparam logic [2:0] COLOR_RED     = 3'd0;
    localparam logic [2:0] COLOR_GREEN   = 3'd1;
    localparam logic [2:0] COLOR_BLUE    = 3'd2;
    localparam logic [2:0] COLOR_MAGENTA = 3'd3;
    localparam logic [2:0] COLOR_YELLOW  = 3'd4;
    localparam logic [2:0] COLOR_CYAN    = 3'd5;
    localparam logic [2:0] COLOR_WHITE   = 3'd6;

    typedef struct packed {
        mode_t            mode;
        logic [2:0]       color;
        logic [MAX_W-1:0] max_level;
    } cfg_t;

    typedef struct packed {
        logic advance;
        op_t  op;
    } step_t;

    // Tick view of the color: the unused code acts as white.
    function automatic logic color_has_red(input logic [2:0] c);
        return (c == COLOR_RED) || (c == COLOR_MAGENTA) || (c == COLOR_YELLOW) ||
               (c >= COLOR_WHITE);
    endfunction

    function automatic logic color_has_green(input logic [2:0] c);
        return (c == COLOR_GREEN) || (c == COLOR_YELLOW) || (c == COLOR_CYAN) ||
               (c >= COLOR_WHITE);
    endfunction

    function automatic logic color_has_blue(input logic [2:0] c);
        return (c == COLOR_BLUE) || (c == COLOR_MAGENTA) || (c == COLOR_CYAN) ||
               (c >= COLOR_WHITE);
    endfunction

    // Restart view of the color: the unused code lights nothing.
    function automatic logic preset_red(input logic [2:0] c);
        return (c == COLOR_RED) || (c == COLOR_MAGENTA) || (c == COLOR_YELLOW) ||
               (c == COLOR_WHITE);
    endfunction

    function automatic logic preset_green(input logic [2:0] c);
        return (c == COLOR_GREEN) || (c == COLOR_YELLOW) || (c == COLOR_CYAN) ||
               (c == COLOR_WHITE);
    endfunction

    function automatic logic preset_blue(input logic [2:0] c);
        return (c == COLOR_BLUE) || (c == COLOR_MAGENTA) || (c == COLOR_CYAN) ||
               (c == COLOR_WHITE);
    endfunction

endpackage

// ===== sv/rgbled_cfg_if.sv =====
// Configuration write channel of the RGB LED effect generator.
// Depends on rgbled_pkg for field widths.
interface rgbled_cfg_if
    import rgbled_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [MAX_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rgbled_cmd_if.sv =====
// Command item channel of the RGB LED effect generator.
// Depends on rgbled_pkg for the operation type and field widths.
interface rgbled_cmd_if
    import rgbled_pkg::*;
;
    logic             valid;
    logic             ready;
    op_t              operation;
    logic [SET_W-1:0] set_red;
    logic [SET_W-1:0] set_green;
    logic [SET_W-1:0] set_blue;

    modport source (output valid, operation, set_red, set_green, set_blue, input ready);
    modport sink   (input valid, operation, set_red, set_green, set_blue, output ready);
endinterface

// ===== sv/rgbled_duty_if.sv =====
// Duty result item channel of the RGB LED effect generator.
// Depends on rgbled_pkg for field widths.
interface rgbled_duty_if
    import rgbled_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DUTY_OUT_W-1:0] red_duty;
    logic [DUTY_OUT_W-1:0] green_duty;
    logic [DUTY_OUT_W-1:0] blue_duty;

    modport source (output valid, red_duty, green_duty, blue_duty, input ready);
    modport sink   (input valid, red_duty, green_duty, blue_duty, output ready);
endinterface

// ===== sv/rgb_led_effect_generator.sv =====
// Top level of the RGB LED effect generator: config registers, item stage, result stage.
// Depends on rgbled_pkg, the three channel interfaces, rgbled_div255, rgbled_fx
// and rgb_led_effect_generator_macros.svh.
//
// Usage:
//   cfg  : write channel; index 0 effect mode, 1 effect color, 2 max level. Always ready;
//          write only while no item is in flight. Index 3 is ignored.
//   cmd  : one item per operation (tick, set, restart, or the no-op code).
//   duty : exactly one result item per command item, carrying the three channel
//          duties after that operation, in command order.
// Pipeline: an accepted item waits in the item register; its result is then presented
//   on duty from the level/result registers once the result register is free or draining.
// Throughput: one item per clock while duty is not held off. The 8x16 set products
//   are formed as the item is registered; the divide by 255 and the effect update sit
//   between the item register and the level/result registers.
// Reset: levels and phase clear to zero, mode off, color red, max level 999; both
//   stages empty.
// Stall: while duty is held off, the result stays put and one more item is taken
//   into the item register; cmd.ready then drops until the result drains.
`include "rgb_led_effect_generator_macros.svh"

module rgb_led_effect_generator
    import rgbled_pkg::*;
#(
    parameter int DUTY_BITS = 16,
    localparam int LevelW = (DUTY_BITS > MAX_W) ? DUTY_BITS : MAX_W
) (
    input  logic          clk,
    input  logic          rst_n,
    rgbled_cfg_if.sink    cfg,
    rgbled_cmd_if.sink    cmd,
    rgbled_duty_if.source duty
);

    // Configuration registers.
    mode_t            mode_reg;
    logic [2:0]       color_reg;
    logic [MAX_W-1:0] max_level_reg;
    cfg_t             cfg_cur;

    // Item stage: operation plus the three set products.
    logic              stage_valid_reg;
    op_t               stage_op_reg;
    logic [PROD_W-1:0] prod_red_reg, prod_green_reg, prod_blue_reg;

    // Result stage: the level registers inside rgbled_fx double as the result.
    logic              duty_valid_reg;
    logic              duty_valid_next;

    logic              advance;
    logic              cmd_take;
    step_t             step;
    logic [MAX_W-1:0]  q_red, q_green, q_blue;
    logic [LevelW-1:0] red_level, green_level, blue_level;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            color_reg     <= COLOR_RED;
            max_level_reg <= MAX_LEVEL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MODE:      mode_reg      <= mode_t'(cfg.data[2:0]);
                REG_COLOR:     color_reg     <= cfg.data[2:0];
                REG_MAX_LEVEL: max_level_reg <= cfg.data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign cfg_cur = '{mode: mode_reg, color: color_reg, max_level: max_level_reg};

    // Move the item forward whenever the result register is free or draining.
    assign advance   = stage_valid_reg && (!duty_valid_reg || duty.ready);
    assign cmd.ready = !stage_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            stage_valid_reg <= cmd.valid;
        end
    end

    // Payload of the item stage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            stage_op_reg   <= cmd.operation;
            prod_red_reg   <= PROD_W'(cmd.set_red) * PROD_W'(max_level_reg);
            prod_green_reg <= PROD_W'(cmd.set_green) * PROD_W'(max_level_reg);
            prod_blue_reg  <= PROD_W'(cmd.set_blue) * PROD_W'(max_level_reg);
        end
    end

    rgbled_div255 u_div_red   (.prod(prod_red_reg),   .quot(q_red));
    rgbled_div255 u_div_green (.prod(prod_green_reg), .quot(q_green));
    rgbled_div255 u_div_blue  (.prod(prod_blue_reg),  .quot(q_blue));

    assign step = '{advance: advance, op: stage_op_reg};

    rgbled_fx #(
        .DUTY_BITS(DUTY_BITS)
    ) u_fx (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_cur),
        .step        (step),
        .set_red_q   (q_red),
        .set_green_q (q_green),
        .set_blue_q  (q_blue),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

    // Result valid: set when an item lands, clear when it is taken.
    always_comb
    begin
        priority if (advance)
        begin
            duty_valid_next = 1'b1;
        end
        else if (duty.ready)
        begin
            duty_valid_next = 1'b0;
        end
        else
        begin
            duty_valid_next = duty_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_valid_reg <= 1'b0;
        end
        else
        begin
            duty_valid_reg <= duty_valid_next;
        end
    end

    assign duty.valid      = duty_valid_reg;
    assign duty.red_duty   = red_level[DUTY_OUT_W-1:0];
    assign duty.green_duty = green_level[DUTY_OUT_W-1:0];
    assign duty.blue_duty  = blue_level[DUTY_OUT_W-1:0];

    `RGBLED_ASSERT_NEXT(a_take_fills_stage, clk, rst_n, cmd_take, stage_valid_reg)
    `RGBLED_ASSERT_NEXT(a_advance_shows_result, clk, rst_n, advance, duty_valid_reg)
    `RGBLED_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_reg && !advance,
        stage_valid_reg)
    `RGBLED_ASSERT_NEXT(a_levels_hold, clk, rst_n, !advance,
        $stable(red_level) && $stable(green_level) && $stable(blue_level))

endmodule

// ===== sv/rgbled_div255.sv =====
// Divide a registered 8x16 product by 255 without a divider.
// Depends on rgbled_pkg for widths and the divisor.
module rgbled_div255
    import rgbled_pkg::*;
(
    input  logic [PROD_W-1:0] prod,
    output logic [MAX_W-1:0]  quot
);

    logic [MAX_W:0]    quot_est;
    logic [PROD_W:0]   est_times;
    logic [PROD_W:0]   rem_full;
    logic [REM_W-1:0]  rem;
    logic [1:0]        corr;

    // p/256 + p/65536 never overshoots p/255 and is short by less than four.
    assign quot_est  = (MAX_W+1)'(prod[PROD_W-1:8]) + (MAX_W+1)'(prod[PROD_W-1:16]);
    assign est_times = {quot_est, 8'd0} - (PROD_W+1)'(quot_est);
    assign rem_full  = (PROD_W+1)'(prod) - est_times;
    assign rem       = rem_full[REM_W-1:0];

    assign corr = 2'(rem >= REM_W'(BYTE_FULL_SCALE)) + 2'(rem >= REM_W'(2 * BYTE_FULL_SCALE))
                + 2'(rem >= REM_W'(3 * BYTE_FULL_SCALE));

    assign quot = MAX_W'(quot_est + (MAX_W+1)'(corr));

endmodule

// ===== sv/rgbled_fx.sv =====
// Channel level and phase registers with the per-item effect update.
// Depends on rgbled_pkg for codes, config struct and color decode.
module rgbled_fx
    import rgbled_pkg::*;
#(
    parameter int DUTY_BITS = 16,
    localparam int LevelW = (DUTY_BITS > MAX_W) ? DUTY_BITS : MAX_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  step_t             step,
    input  logic [MAX_W-1:0]  set_red_q,
    input  logic [MAX_W-1:0]  set_green_q,
    input  logic [MAX_W-1:0]  set_blue_q,
    output logic [LevelW-1:0] red_level,
    output logic [LevelW-1:0] green_level,
    output logic [LevelW-1:0] blue_level
);

    localparam logic [LevelW-1:0] LevelMask = LevelW'({DUTY_BITS{1'b1}});

    logic [LevelW-1:0] red_level_reg, green_level_reg, blue_level_reg;
    logic [LevelW-1:0] red_level_next, green_level_next, blue_level_next;
    logic [1:0]        phase_reg, phase_next;
    logic [LevelW-1:0] max_ext;
    logic [LevelW-1:0] lead;
    logic [LevelW-1:0] lead_next;
    logic [LevelW-1:0] red_dn, red_up, green_dn, green_up, blue_dn, blue_up;

    function automatic logic [LevelW-1:0] lvl_dn(input logic [LevelW-1:0] v);
        return (v - LevelW'(1)) & LevelMask;
    endfunction

    function automatic logic [LevelW-1:0] lvl_up(input logic [LevelW-1:0] v);
        return (v + LevelW'(1)) & LevelMask;
    endfunction

    assign max_ext  = LevelW'(cfg.max_level);
    assign red_dn   = lvl_dn(red_level_reg);
    assign red_up   = lvl_up(red_level_reg);
    assign green_dn = lvl_dn(green_level_reg);
    assign green_up = lvl_up(green_level_reg);
    assign blue_dn  = lvl_dn(blue_level_reg);
    assign blue_up  = lvl_up(blue_level_reg);

    // Breath lead channel: green for green and cyan, blue for blue, else red.
    always_comb
    begin
        if ((cfg.color == COLOR_GREEN) || (cfg.color == COLOR_CYAN))
        begin
            lead = green_level_reg;
        end
        else if (cfg.color == COLOR_BLUE)
        begin
            lead = blue_level_reg;
        end
        else
        begin
            lead = red_level_reg;
        end
        lead_next = (phase_reg == 2'd0) ? lvl_dn(lead) : lvl_up(lead);
    end

    always_comb
    begin
        red_level_next   = red_level_reg;
        green_level_next = green_level_reg;
        blue_level_next  = blue_level_reg;
        phase_next       = phase_reg;
        if (step.advance)
        begin
            unique case (step.op)
                OP_TICK:
                begin
                    unique case (cfg.mode)
                        MODE_OFF:
                        begin
                            red_level_next   = '0;
                            green_level_next = '0;
                            blue_level_next  = '0;
                        end
                        MODE_STATIC:
                        begin
                            if (color_has_red(cfg.color))   red_level_next   = max_ext;
                            if (color_has_green(cfg.color)) green_level_next = max_ext;
                            if (color_has_blue(cfg.color))  blue_level_next  = max_ext;
                        end
                        MODE_BLINK:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                red_level_next   = '0;
                                green_level_next = '0;
                                blue_level_next  = '0;
                                phase_next       = 2'd1;
                            end
                            else
                            begin
                                if (color_has_red(cfg.color))   red_level_next   = max_ext;
                                if (color_has_green(cfg.color)) green_level_next = max_ext;
                                if (color_has_blue(cfg.color))  blue_level_next  = max_ext;
                                phase_next = 2'd0;
                            end
                        end
                        MODE_BREATH:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                if (lead_next == '0) phase_next = 2'd1;
                            end
                            else if (lead_next == max_ext)
                            begin
                                phase_next = 2'd0;
                            end
                            if ((cfg.color == COLOR_GREEN) || (cfg.color == COLOR_CYAN))
                            begin
                                green_level_next = lead_next;
                                if (cfg.color == COLOR_CYAN) blue_level_next = lead_next;
                            end
                            else if (cfg.color == COLOR_BLUE)
                            begin
                                blue_level_next = lead_next;
                            end
                            else
                            begin
                                red_level_next = lead_next;
                                if ((cfg.color == COLOR_MAGENTA) || (cfg.color >= COLOR_WHITE))
                                    blue_level_next = lead_next;
                                if ((cfg.color == COLOR_YELLOW) || (cfg.color >= COLOR_WHITE))
                                    green_level_next = lead_next;
                            end
                        end
                        MODE_SMOOTH:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                red_level_next  = red_dn;
                                blue_level_next = blue_up;
                                if ((red_dn == '0) && (blue_up == max_ext)) phase_next = 2'd1;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                blue_level_next  = blue_dn;
                                green_level_next = green_up;
                                if ((blue_dn == '0) && (green_up == max_ext)) phase_next = 2'd2;
                            end
                            else
                            begin
                                green_level_next = green_dn;
                                red_level_next   = red_up;
                                if ((green_dn == '0) && (red_up == max_ext)) phase_next = 2'd0;
                            end
                        end
                        default:
                        begin
                            // unused mode codes leave everything as is
                        end
                    endcase
                end
                OP_SET:
                begin
                    red_level_next   = LevelW'(set_red_q) & LevelMask;
                    green_level_next = LevelW'(set_green_q) & LevelMask;
                    blue_level_next  = LevelW'(set_blue_q) & LevelMask;
                end
                OP_RESTART:
                begin
                    red_level_next   = '0;
                    green_level_next = '0;
                    blue_level_next  = '0;
                    if (cfg.mode == MODE_BREATH)
                    begin
                        if (preset_red(cfg.color))   red_level_next   = max_ext;
                        if (preset_green(cfg.color)) green_level_next = max_ext;
                        if (preset_blue(cfg.color))  blue_level_next  = max_ext;
                    end
                    else if (cfg.mode == MODE_SMOOTH)
                    begin
                        red_level_next = max_ext;
                    end
                    phase_next = 2'd0;
                end
                OP_NOP:
                begin
                    // report the current levels unchanged
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_level_reg   <= '0;
            green_level_reg <= '0;
            blue_level_reg  <= '0;
            phase_reg       <= 2'd0;
        end
        else
        begin
            red_level_reg   <= red_level_next;
            green_level_reg <= green_level_next;
            blue_level_reg  <= blue_level_next;
            phase_reg       <= phase_next;
        end
    end

    assign red_level   = red_level_reg;
    assign green_level = green_level_reg;
    assign blue_level  = blue_level_reg;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the RGB LED effect generator.
// Depends on rgbled_pkg, the cfg, cmd and duty channel interfaces, and the
// rgb_led_effect_generator top level.
module tb;
    import rgbled_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RAND_ITEMS = 450;

    // Codes outside the documented range; the block must still handle them.
    localparam logic [2:0] MODE_SPARE  = 3'd7;
    localparam logic [2:0] COLOR_SPARE = 3'd7;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    // Channel duties of one result item: [0] red, [1] green, [2] blue.
    typedef logic [2:0][DUTY_OUT_W-1:0] duty_set_t;

    typedef struct packed {
        op_t              op;
        logic [SET_W-1:0] red;
        logic [SET_W-1:0] green;
        logic [SET_W-1:0] blue;
    } cmd_item_t;

    logic clk = 1'b0;
    logic rst_n;

    rgbled_cfg_if  cfg_ch ();
    rgbled_cmd_if  cmd_ch ();
    rgbled_duty_if duty_ch ();

    rgb_led_effect_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .duty  (duty_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Command items waiting to be offered, and duties still owed by the block.
    cmd_item_t cmd_pending_q[$];
    duty_set_t duty_owed_q[$];

    int    err_count = 0;
    int    idle_pct  = 17;
    bit    cmd_fired = 1'b0;
    string chan_label [3] = '{"red", "green", "blue"};

    // Shadow of the configuration registers and of the effect state.
    logic [2:0]       cfg_mode;
    logic [2:0]       cfg_color;
    logic [MAX_W-1:0] cfg_max;
    logic [15:0]      lvl_r;
    logic [15:0]      lvl_g;
    logic [15:0]      lvl_b;
    logic [1:0]       fx_phase;

    // Channels a color lights on a tick: bit 0 red, bit 1 green, bit 2 blue.
    // The spare color code acts as white here.
    function automatic logic [2:0] lit_mask(input logic [2:0] c);
        case (c)
            COLOR_RED:     return 3'b001;
            COLOR_GREEN:   return 3'b010;
            COLOR_BLUE:    return 3'b100;
            COLOR_MAGENTA: return 3'b101;
            COLOR_YELLOW:  return 3'b011;
            COLOR_CYAN:    return 3'b110;
            default:       return 3'b111;
        endcase
    endfunction

    function automatic void light(input logic [2:0] m);
        if (m[0]) lvl_r = cfg_max;
        if (m[1]) lvl_g = cfg_max;
        if (m[2]) lvl_b = cfg_max;
    endfunction

    // One breath step of the lead channel; flip direction at either end of travel.
    function automatic logic [15:0] breath_step(input logic [15:0] v);
        if (fx_phase == 2'd0) begin
            v = v - 16'd1;
            if (v == 16'd0) fx_phase = 2'd1;
        end
        else begin
            v = v + 16'd1;
            if (v == cfg_max) fx_phase = 2'd0;
        end
        return v;
    endfunction

    // Advance the shadow state by one command item and return the duties it yields.
    function automatic duty_set_t apply_item(input op_t op, input logic [SET_W-1:0] r,
                                             input logic [SET_W-1:0] g,
                                             input logic [SET_W-1:0] b);
        logic [2:0] m;
        m = lit_mask(cfg_color);
        case (op)
            OP_TICK:
            begin
                case (cfg_mode)
                    MODE_OFF:
                    begin
                        lvl_r = '0;
                        lvl_g = '0;
                        lvl_b = '0;
                    end
                    MODE_STATIC: light(m);
                    MODE_BLINK:
                    begin
                        if (fx_phase == 2'd0) begin
                            lvl_r    = '0;
                            lvl_g    = '0;
                            lvl_b    = '0;
                            fx_phase = 2'd1;
                        end
                        else begin
                            light(m);
                            fx_phase = 2'd0;
                        end
                    end
                    MODE_BREATH:
                    begin
                        // Step the lead channel; the other lit channels follow it.
                        if (cfg_color == COLOR_GREEN || cfg_color == COLOR_CYAN) begin
                            lvl_g = breath_step(lvl_g);
                            if (m[2]) lvl_b = lvl_g;
                        end
                        else if (cfg_color == COLOR_BLUE) begin
                            lvl_b = breath_step(lvl_b);
                        end
                        else begin
                            lvl_r = breath_step(lvl_r);
                            if (m[2]) lvl_b = lvl_r;
                            if (m[1]) lvl_g = lvl_r;
                        end
                    end
                    MODE_SMOOTH:
                    begin
                        // Crossfade red->blue, blue->green, green->red.
                        if (fx_phase == 2'd0) begin
                            lvl_r = lvl_r - 16'd1;
                            lvl_b = lvl_b + 16'd1;
                            if (lvl_r == 16'd0 && lvl_b == cfg_max) fx_phase = 2'd1;
                        end
                        else if (fx_phase == 2'd1) begin
                            lvl_b = lvl_b - 16'd1;
                            lvl_g = lvl_g + 16'd1;
                            if (lvl_b == 16'd0 && lvl_g == cfg_max) fx_phase = 2'd2;
                        end
                        else begin
                            lvl_g = lvl_g - 16'd1;
                            lvl_r = lvl_r + 16'd1;
                            if (lvl_g == 16'd0 && lvl_r == cfg_max) fx_phase = 2'd0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_SET:
            begin
                lvl_r = 16'((int'(r) * int'(cfg_max)) / BYTE_FULL_SCALE);
                lvl_g = 16'((int'(g) * int'(cfg_max)) / BYTE_FULL_SCALE);
                lvl_b = 16'((int'(b) * int'(cfg_max)) / BYTE_FULL_SCALE);
            end
            OP_RESTART:
            begin
                lvl_r = '0;
                lvl_g = '0;
                lvl_b = '0;
                // The preset ignores the spare color code.
                if (cfg_mode == MODE_BREATH) begin
                    if (cfg_color != COLOR_SPARE) light(m);
                end
                else if (cfg_mode == MODE_SMOOTH) begin
                    lvl_r = cfg_max;
                end
                fx_phase = 2'd0;
            end
            default: ;
        endcase
        return {lvl_b, lvl_g, lvl_r};
    endfunction

    // Write one register while the block is idle; update the shadow on the handshake.
    task automatic write_reg(input logic [1:0] idx, input logic [MAX_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_MODE:      cfg_mode  = value[2:0];
            REG_COLOR:     cfg_color = value[2:0];
            REG_MAX_LEVEL: cfg_max   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold until every queued item is taken and every owed duty has come back.
    task automatic wait_drained();
        do @(negedge clk); while (cmd_pending_q.size() != 0 || duty_owed_q.size() != 0);
    endtask

    task automatic push_item(input op_t op, input logic [SET_W-1:0] r,
                             input logic [SET_W-1:0] g, input logic [SET_W-1:0] b);
        cmd_pending_q.push_back('{op: op, red: r, green: g, blue: b});
    endtask

    // Favor the ends of the 8-bit range now and then.
    function automatic logic [SET_W-1:0] rand_level();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return SET_W'($urandom());
    endfunction

    // Command driver: change inputs on the falling edge, hold an offered item until taken.
    always @(negedge clk) begin
        if (rst_n && (!cmd_ch.valid || cmd_fired)) begin
            if (cmd_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cmd_ch.valid     <= 1'b1;
                cmd_ch.operation <= cmd_pending_q[0].op;
                cmd_ch.set_red   <= cmd_pending_q[0].red;
                cmd_ch.set_green <= cmd_pending_q[0].green;
                cmd_ch.set_blue  <= cmd_pending_q[0].blue;
            end
            else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // On every accepted command item, predict its duties and retire it from the queue.
    always @(posedge clk) begin
        cmd_fired = rst_n && cmd_ch.valid && cmd_ch.ready;
        if (cmd_fired) begin
            duty_owed_q.push_back(apply_item(cmd_ch.operation, cmd_ch.set_red,
                                             cmd_ch.set_green, cmd_ch.set_blue));
            void'(cmd_pending_q.pop_front());
        end
    end

    // Duty receiver: stall at random on the falling edge.
    always @(negedge clk) begin
        if (rst_n) duty_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Compare each accepted duty item, channel by channel, with the oldest prediction.
    always @(posedge clk) begin
        duty_set_t got;
        duty_set_t want;
        if (rst_n && duty_ch.valid && duty_ch.ready) begin
            got = {duty_ch.blue_duty, duty_ch.green_duty, duty_ch.red_duty};
            if (duty_owed_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected duty item, expected none, got r=%0d g=%0d b=%0d",
                         $time, got[0], got[1], got[2]);
            end
            else begin
                want = duty_owed_q.pop_front();
                for (int ch = 0; ch < 3; ch++) begin
                    if (got[ch] !== want[ch]) begin
                        err_count++;
                        $display("%0t: %s duty expected %0d, got %0d",
                                 $time, chan_label[ch], want[ch], got[ch]);
                    end
                end
            end
        end
    end

    // Stimulus: reset, a directed pass over modes and corner codes, then random phases.
    initial begin
        int        rand_items;
        int        phase_no;
        int        burst;
        int        roll;
        logic [2:0] pick_mode;
        logic [MAX_W-1:0] pick_max;
        op_t       pick_op;

        // Drive every input to a known value before the first edge.
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_MODE;
        cfg_ch.data       = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = OP_TICK;
        cmd_ch.set_red    = '0;
        cmd_ch.set_green  = '0;
        cmd_ch.set_blue   = '0;
        duty_ch.ready     = 1'b0;

        cfg_mode  = MODE_OFF;
        cfg_color = COLOR_RED;
        cfg_max   = MAX_LEVEL_RESET;
        lvl_r     = '0;
        lvl_g     = '0;
        lvl_b     = '0;
        fx_phase  = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset config: set at both ends of the 8-bit range, the no-op code, off tick, restart.
        push_item(OP_SET, 8'hFF, 8'hFF, 8'hFF);
        push_item(OP_SET, 8'h00, 8'h00, 8'h00);
        push_item(OP_SET, 8'hAA, 8'h55, 8'h01);
        push_item(OP_NOP, 8'h00, 8'h00, 8'h00);
        push_item(OP_TICK, 8'h00, 8'h00, 8'h00);
        push_item(OP_RESTART, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Static white at the top duty value: a set over mixed levels, then a tick.
        write_reg(REG_MODE, {13'h0, MODE_STATIC});
        write_reg(REG_COLOR, {13'h0, COLOR_WHITE});
        write_reg(REG_MAX_LEVEL, 16'hFFFF);
        push_item(OP_SET, 8'h80, 8'h00, 8'hFF);
        push_item(OP_TICK, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Blink magenta: off, on, off.
        write_reg(REG_MODE, {13'h0, MODE_BLINK});
        write_reg(REG_COLOR, {13'h0, COLOR_MAGENTA});
        write_reg(REG_MAX_LEVEL, 16'd5);
        repeat (3) push_item(OP_TICK, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Breath cyan over a full down and up swing.
        write_reg(REG_MODE, {13'h0, MODE_BREATH});
        write_reg(REG_COLOR, {13'h0, COLOR_CYAN});
        write_reg(REG_MAX_LEVEL, 16'd2);
        push_item(OP_RESTART, 8'h00, 8'h00, 8'h00);
        repeat (4) push_item(OP_TICK, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Smooth cycle at the smallest max level: each crossfade finishes in one tick.
        write_reg(REG_MODE, {13'h0, MODE_SMOOTH});
        write_reg(REG_MAX_LEVEL, 16'd1);
        push_item(OP_RESTART, 8'h00, 8'h00, 8'h00);
        repeat (4) push_item(OP_TICK, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Spare mode freezes levels; spare color: dark preset, white tick; spare index.
        write_reg(REG_MODE, {13'h1FFF, MODE_SPARE});
        write_reg(REG_COLOR, {13'h1FFF, COLOR_SPARE});
        write_reg(REG_SPARE, 16'hFFFF);
        push_item(OP_TICK, 8'h00, 8'h00, 8'h00);
        wait_drained();
        write_reg(REG_MODE, {13'h0, MODE_BREATH});
        push_item(OP_RESTART, 8'h00, 8'h00, 8'h00);
        push_item(OP_TICK, 8'h00, 8'h00, 8'h00);

        // Random phases: drain, reprogram, then a burst that mostly starts with a restart
        // and is mostly ticks, so the effects get deep into their cycles.
        rand_items = 0;
        phase_no   = 0;
        while (rand_items < RAND_ITEMS) begin
            wait_drained();

            roll      = $urandom_range(99);
            pick_mode = (roll < 88) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
            write_reg(REG_MODE, {13'($urandom()), pick_mode});
            if ($urandom_range(99) < 80)
                write_reg(REG_COLOR, {13'($urandom()), 3'($urandom_range(7))});
            roll = $urandom_range(99);
            if (roll < 50)      pick_max = 16'($urandom_range(1, 8));
            else if (roll < 75) pick_max = 16'($urandom_range(9, 300));
            else if (roll < 85) pick_max = 16'hFFFF;
            else                pick_max = 16'($urandom_range(1, 65535));
            if ($urandom_range(99) < 75) write_reg(REG_MAX_LEVEL, pick_max);
            if ($urandom_range(99) < 5) write_reg(REG_SPARE, 16'($urandom()));

            // One long phase runs with no idling on either side.
            idle_pct = (phase_no == 3) ? 0 : 17;
            burst    = (phase_no == 3) ? 80 : $urandom_range(8, 40);

            if ($urandom_range(99) < 80) begin
                push_item(OP_RESTART, rand_level(), rand_level(), rand_level());
                rand_items++;
            end
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < 70)      pick_op = OP_TICK;
                else if (roll < 82) pick_op = OP_SET;
                else if (roll < 94) pick_op = OP_RESTART;
                else                pick_op = OP_NOP;
                push_item(pick_op, rand_level(), rand_level(), rand_level());
                rand_items++;
            end
            phase_no++;
        end

        // Drain, give any stray duty item a few edges to show up, then report.
        wait_drained();
        repeat (4) @(posedge clk);
        if (duty_owed_q.size() != 0) err_count++;
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hang anywhere in the handshakes.
    initial begin
        #(CLK_PERIOD * 400000);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== rgb_led_effect_generator.f =====
+incdir+sv
sv/rgbled_pkg.sv
sv/rgbled_cfg_if.sv
sv/rgbled_cmd_if.sv
sv/rgbled_duty_if.sv
sv/rgbled_div255.sv
sv/rgbled_fx.sv
sv/rgb_led_effect_generator.sv
tb/sv/tb.sv
